>>> rtl/cst_pkg.sv
// Package for the connection and slot table block.
// Command codes, status codes and fixed field widths; no dependencies.
package cst_pkg;

  localparam int FUNC_W   = 3;
  localparam int ID_W     = 16;
  localparam int REQ_W    = 8;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_CONNECT    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DISCONNECT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ASSIGN     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ASSIGN_REQ = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

endpackage

>>> rtl/cst_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on cst_pkg for field widths.
interface cst_in_if;
  logic                           valid;
  logic                           ready;
  logic [cst_pkg::FUNC_W-1:0]     func;
  logic [cst_pkg::ID_W-1:0]       session_id;
  logic [cst_pkg::REQ_W-1:0]      requested_slot;

  modport source (output valid, output func, output session_id, output requested_slot,
                  input ready);
  modport sink   (input valid, input func, input session_id, input requested_slot,
                  output ready);
endinterface

interface cst_out_if;
  logic                           valid;
  logic                           ready;
  logic                           is_linked;
  logic [cst_pkg::SLOT_W-1:0]     slot;
  logic [cst_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output is_linked, output slot, output status,
                  input ready);
  modport sink   (input valid, input is_linked, input slot, input status,
                  output ready);
endinterface

>>> rtl/cst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/connection_and_slot_table_top.sv
// Connection table and slot-ownership table with a scanning sequencer.
// Depends on cst_pkg, cst_in_if / cst_out_if and cst_ram.
//
//   channel   dir   handshake     payload
//   in_ch     in    valid/ready   func, session_id, requested_slot
//   out_ch    out   valid/ready   is_linked, slot, status
//
// One item scans both tables together, one entry a cycle through a shared
// scan counter, with registered RAM reads; the FIN state then decides and
// writes. A zero id or an unused code skips the scan and goes straight to
// FIN.
// Reset clears all valid bits at once; no clearing pass.
// A result waits in the output register; the next item is taken meanwhile,
// and only the final write step holds while that register is full.
module connection_and_slot_table_top #(
  parameter int LINK_SLOTS  = 16,
  parameter int OWNER_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  cst_in_if.sink    in_ch,
  cst_out_if.source out_ch
);

  localparam int LW     = $clog2(LINK_SLOTS);
  localparam int OW     = $clog2(OWNER_SLOTS);
  localparam int SCAN_N = (LINK_SLOTS > OWNER_SLOTS) ? LINK_SLOTS : OWNER_SLOTS;
  localparam int SW     = $clog2(SCAN_N + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [SW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] pidx_r, pidx_nxt;
  logic          pend_r, pend_nxt;

  logic [cst_pkg::FUNC_W-1:0] func_r, func_nxt;
  logic [cst_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [cst_pkg::REQ_W-1:0]  req_r, req_nxt;

  logic          lhit_f_r, lhit_f_nxt, lfree_f_r, lfree_f_nxt;
  logic [LW-1:0] lhit_idx_r, lhit_idx_nxt, lfree_idx_r, lfree_idx_nxt;
  logic          ohit_f_r, ohit_f_nxt, ofree_f_r, ofree_f_nxt;
  logic [OW-1:0] ohit_idx_r, ohit_idx_nxt, ofree_idx_r, ofree_idx_nxt;

  logic [LINK_SLOTS-1:0]  link_valid_r, link_valid_nxt;
  logic [OWNER_SLOTS-1:0] slot_valid_r, slot_valid_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_linked_r, out_linked_nxt;
  logic [cst_pkg::SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [cst_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;

  logic                   link_we, own_we;
  logic [LW-1:0]          link_waddr;
  logic [OW-1:0]          own_waddr;
  logic [cst_pkg::ID_W-1:0] link_rdata, own_rdata;

  logic                   in_fire, skip, req_ok;
  logic [LW-1:0]          pidx_l;
  logic [OW-1:0]          pidx_o;

  cst_ram #(.WIDTH(cst_pkg::ID_W), .DEPTH(LINK_SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (id_r),
    .raddr (cnt_r[LW-1:0]),
    .rdata (link_rdata)
  );

  cst_ram #(.WIDTH(cst_pkg::ID_W), .DEPTH(OWNER_SLOTS)) u_own_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (id_r),
    .raddr (cnt_r[OW-1:0]),
    .rdata (own_rdata)
  );

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign in_fire          = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.is_linked = out_linked_r;
  assign out_ch.slot      = out_slot_r;
  assign out_ch.status    = out_status_r;

  assign skip   = (in_ch.func > cst_pkg::FUNC_ASSIGN_REQ) || (in_ch.session_id == '0);
  assign pidx_l = pidx_r[LW-1:0];
  assign pidx_o = pidx_r[OW-1:0];
  assign req_ok = ({1'b0, req_r} < 9'(OWNER_SLOTS)) && !slot_valid_r[req_r[OW-1:0]];

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pidx_nxt       = pidx_r;
    pend_nxt       = 1'b0;
    func_nxt       = func_r;
    id_nxt         = id_r;
    req_nxt        = req_r;
    lhit_f_nxt     = lhit_f_r;
    lhit_idx_nxt   = lhit_idx_r;
    lfree_f_nxt    = lfree_f_r;
    lfree_idx_nxt  = lfree_idx_r;
    ohit_f_nxt     = ohit_f_r;
    ohit_idx_nxt   = ohit_idx_r;
    ofree_f_nxt    = ofree_f_r;
    ofree_idx_nxt  = ofree_idx_r;
    link_valid_nxt = link_valid_r;
    slot_valid_nxt = slot_valid_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_linked_nxt = out_linked_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    link_we        = 1'b0;
    own_we         = 1'b0;
    link_waddr     = lfree_idx_r;
    own_waddr      = ofree_idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt    = in_ch.func;
          id_nxt      = in_ch.session_id;
          req_nxt     = in_ch.requested_slot;
          cnt_nxt     = '0;
          lhit_f_nxt  = 1'b0;
          lfree_f_nxt = 1'b0;
          ohit_f_nxt  = 1'b0;
          ofree_f_nxt = 1'b0;
          state_nxt   = skip ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r < SW'(SCAN_N)) begin
          pidx_nxt = cnt_r;
          pend_nxt = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = ST_FIN;
        end
        if (pend_r) begin
          if (pidx_r < SW'(LINK_SLOTS)) begin
            if (link_valid_r[pidx_l] && (link_rdata == id_r) && !lhit_f_r) begin
              lhit_f_nxt   = 1'b1;
              lhit_idx_nxt = pidx_l;
            end
            if (!link_valid_r[pidx_l] && !lfree_f_r) begin
              lfree_f_nxt   = 1'b1;
              lfree_idx_nxt = pidx_l;
            end
          end
          if (pidx_r < SW'(OWNER_SLOTS)) begin
            if (slot_valid_r[pidx_o] && (own_rdata == id_r) && !ohit_f_r) begin
              ohit_f_nxt   = 1'b1;
              ohit_idx_nxt = pidx_o;
            end
            if (!slot_valid_r[pidx_o] && !ofree_f_r) begin
              ofree_f_nxt   = 1'b1;
              ofree_idx_nxt = pidx_o;
            end
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_linked_nxt = 1'b0;
          out_slot_nxt   = '0;
          out_status_nxt = cst_pkg::STATUS_OK;
          if (func_r > cst_pkg::FUNC_ASSIGN_REQ) begin
            out_status_nxt = cst_pkg::STATUS_OK;
          end else if (id_r == '0) begin
            out_status_nxt = cst_pkg::STATUS_NOT_FOUND;
          end else begin
            case (func_r)
              cst_pkg::FUNC_CONNECT: begin
                if (lfree_f_r) begin
                  link_we                     = 1'b1;
                  link_valid_nxt[lfree_idx_r] = 1'b1;
                  out_slot_nxt                = 4'(lfree_idx_r);
                end else begin
                  out_status_nxt = cst_pkg::STATUS_FULL;
                end
              end
              cst_pkg::FUNC_DISCONNECT: begin
                if (lhit_f_r) begin
                  link_valid_nxt[lhit_idx_r] = 1'b0;
                  out_slot_nxt               = 4'(lhit_idx_r);
                end else begin
                  out_status_nxt = cst_pkg::STATUS_NOT_FOUND;
                end
                if (ohit_f_r) begin
                  slot_valid_nxt[ohit_idx_r] = 1'b0;
                end
              end
              cst_pkg::FUNC_QUERY: begin
                if (lhit_f_r) begin
                  out_linked_nxt = 1'b1;
                  out_slot_nxt   = 4'(lhit_idx_r);
                end else begin
                  out_status_nxt = cst_pkg::STATUS_NOT_FOUND;
                end
              end
              cst_pkg::FUNC_ASSIGN, cst_pkg::FUNC_ASSIGN_REQ: begin
                if (ohit_f_r) begin
                  out_slot_nxt = 4'(ohit_idx_r);
                end else if ((func_r == cst_pkg::FUNC_ASSIGN_REQ) && req_ok) begin
                  own_we                          = 1'b1;
                  own_waddr                       = req_r[OW-1:0];
                  slot_valid_nxt[req_r[OW-1:0]]   = 1'b1;
                  out_slot_nxt                    = req_r[cst_pkg::SLOT_W-1:0];
                end else if (ofree_f_r) begin
                  own_we                      = 1'b1;
                  slot_valid_nxt[ofree_idx_r] = 1'b1;
                  out_slot_nxt                = 4'(ofree_idx_r);
                end else begin
                  out_status_nxt = cst_pkg::STATUS_FULL;
                end
              end
              default: begin
                out_status_nxt = cst_pkg::STATUS_OK;
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      link_valid_r <= '0;
      slot_valid_r <= '0;
    end else begin
      state_r      <= state_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
      link_valid_r <= link_valid_nxt;
      slot_valid_r <= slot_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    pidx_r       <= pidx_nxt;
    func_r       <= func_nxt;
    id_r         <= id_nxt;
    req_r        <= req_nxt;
    lhit_f_r     <= lhit_f_nxt;
    lhit_idx_r   <= lhit_idx_nxt;
    lfree_f_r    <= lfree_f_nxt;
    lfree_idx_r  <= lfree_idx_nxt;
    ohit_f_r     <= ohit_f_nxt;
    ohit_idx_r   <= ohit_idx_nxt;
    ofree_f_r    <= ofree_f_nxt;
    ofree_idx_r  <= ofree_idx_nxt;
    out_linked_r <= out_linked_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

>>> tb/cst_table_checker.sv
`timescale 1ns / 100ps
// Checker for connection_and_slot_table_top: keeps its own copy of both tables,
// predicts the reply to each accepted command and compares replies in order.
// Depends on cst_pkg and the cst_in_if / cst_out_if channel interfaces.
module cst_table_checker #(
  parameter int LINK_SLOTS  = 16,
  parameter int OWNER_SLOTS = 16
) (
  input  logic clk,
  input  logic rst_n,
  cst_in_if    in_mon,
  cst_out_if   out_mon,
  output int   fail_count,
  output int   outstanding
);

  typedef logic [cst_pkg::FUNC_W-1:0] func_t;
  typedef logic [cst_pkg::ID_W-1:0]   id_t;
  typedef logic [cst_pkg::REQ_W-1:0]  req_t;
  typedef logic [cst_pkg::SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic                         is_linked;
    slot_t                        slot;
    logic [cst_pkg::STATUS_W-1:0] status;
  } reply_t;

  logic conn_valid [LINK_SLOTS];
  id_t  conn_id    [LINK_SLOTS];
  id_t  slot_id    [OWNER_SLOTS];

  reply_t pending_replies[$];
  int     failures = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // Applies one command to the shadow tables and returns the reply it earns.
  function automatic reply_t table_update(input func_t f, input id_t id, input req_t rs);
    reply_t r;
    int     conn_hit;
    int     conn_free;
    int     owned;
    int     free_slot;
    r         = '0;
    conn_hit  = -1;
    conn_free = -1;
    owned     = -1;
    free_slot = -1;
    if (f > cst_pkg::FUNC_ASSIGN_REQ) return r;
    if (id == '0) begin
      r.status = cst_pkg::STATUS_NOT_FOUND;
      return r;
    end
    for (int i = 0; i < LINK_SLOTS; i++) begin
      if (conn_hit < 0 && conn_valid[i] && conn_id[i] == id) conn_hit = i;
      if (conn_free < 0 && !conn_valid[i]) conn_free = i;
    end
    for (int i = 0; i < OWNER_SLOTS; i++) begin
      if (owned < 0 && slot_id[i] == id) owned = i;
      if (free_slot < 0 && slot_id[i] == '0) free_slot = i;
    end
    case (f)
      cst_pkg::FUNC_CONNECT: begin
        if (conn_free < 0) begin
          r.status = cst_pkg::STATUS_FULL;
        end else begin
          conn_valid[conn_free] = 1'b1;
          conn_id[conn_free]    = id;
          r.slot                = slot_t'(conn_free);
        end
      end
      cst_pkg::FUNC_DISCONNECT: begin
        if (conn_hit >= 0) begin
          conn_valid[conn_hit] = 1'b0;
          r.slot               = slot_t'(conn_hit);
        end else begin
          r.status = cst_pkg::STATUS_NOT_FOUND;
        end
        if (owned >= 0) slot_id[owned] = '0;
      end
      cst_pkg::FUNC_QUERY: begin
        if (conn_hit >= 0) begin
          r.is_linked = 1'b1;
          r.slot      = slot_t'(conn_hit);
        end else begin
          r.status = cst_pkg::STATUS_NOT_FOUND;
        end
      end
      default: begin
        if (owned >= 0) begin
          r.slot = slot_t'(owned);
        end else if (f == cst_pkg::FUNC_ASSIGN_REQ && rs < OWNER_SLOTS &&
                     slot_id[rs] == '0) begin
          slot_id[rs] = id;
          r.slot      = slot_t'(rs);
        end else if (free_slot < 0) begin
          r.status = cst_pkg::STATUS_FULL;
        end else begin
          slot_id[free_slot] = id;
          r.slot             = slot_t'(free_slot);
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reply_t want;
    reply_t got;
    if (!rst_n) begin
      for (int i = 0; i < LINK_SLOTS; i++) begin
        conn_valid[i] = 1'b0;
        conn_id[i]    = '0;
      end
      for (int i = 0; i < OWNER_SLOTS; i++) slot_id[i] = '0;
      pending_replies.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        pending_replies.push_back(table_update(in_mon.func, in_mon.session_id,
                                               in_mon.requested_slot));
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.is_linked, out_mon.slot, out_mon.status};
        if (pending_replies.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: unexpected reply linked=%0d slot=%0d status=%0d",
                     $realtime, got.is_linked, got.slot, got.status);
        end else begin
          want = pending_replies.pop_front();
          if (got.is_linked !== want.is_linked || got.slot !== want.slot ||
              got.status !== want.status) begin
            failures++;
            if (failures <= 10)
              $display({"%0t: reply mismatch: expected linked=%0d slot=%0d status=%0d,",
                        " got linked=%0d slot=%0d status=%0d"},
                       $realtime, want.is_linked, want.slot, want.status,
                       got.is_linked, got.slot, got.status);
          end
        end
      end
    end
    outstanding <= pending_replies.size();
    fail_count  <= failures;
  end

endmodule

>>> tb/connection_and_slot_table_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for connection_and_slot_table_top: clock, reset, command stimulus
// with bursty sender and stalling receiver, and the final verdict.
// Depends on cst_pkg, cst_in_if / cst_out_if, the block and cst_table_checker.
module connection_and_slot_table_top_tb;

  localparam int NUM_COMMANDS = 950;
  localparam int POOL_SIZE    = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 40;

  typedef logic [cst_pkg::FUNC_W-1:0] func_t;
  typedef logic [cst_pkg::ID_W-1:0]   id_t;
  typedef logic [cst_pkg::REQ_W-1:0]  req_t;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   outstanding;

  cst_in_if  in_ch ();
  cst_out_if out_ch ();

  connection_and_slot_table_top #(
    .LINK_SLOTS  (16),
    .OWNER_SLOTS (16)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cst_table_checker #(
    .LINK_SLOTS  (16),
    .OWNER_SLOTS (16)
  ) chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #3_200_000;
    $display("connection_and_slot_table_top regression: fail");
    $finish;
  end

  id_t id_pool [POOL_SIZE];
  int  sent        = 0;
  int  burst_left  = 0;
  bit  offering    = 1'b0;
  int  hold_requests = 0;

  // Receiver: random stall modes in spans, plus long hold-offs on request.
  initial begin : receiver
    int mode;
    int span;
    int holds_done;
    mode       = 0;
    span       = 0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 2);
          span = $urandom_range(10, 80);
        end
        span--;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  task automatic issue(input func_t f, input id_t id, input req_t rs);
    int gap;
    in_ch.valid          <= 1'b1;
    in_ch.func           <= f;
    in_ch.session_id     <= id;
    in_ch.requested_slot <= rs;
    offering = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic id_t pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 12) return id_t'($urandom_range(1, 65535));
    return id_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic req_t pick_req();
    if ($urandom_range(0, 9) < 7) return req_t'($urandom_range(0, 15));
    return req_t'($urandom_range(0, 255));
  endfunction

  function automatic func_t pick_func();
    int r;
    r = $urandom_range(0, 19);
    if (r < 4) return cst_pkg::FUNC_CONNECT;
    if (r < 8) return cst_pkg::FUNC_DISCONNECT;
    if (r < 12) return cst_pkg::FUNC_QUERY;
    if (r < 15) return cst_pkg::FUNC_ASSIGN;
    if (r < 19) return cst_pkg::FUNC_ASSIGN_REQ;
    return func_t'($urandom_range(cst_pkg::FUNC_ASSIGN_REQ + 1, 7));
  endfunction

  initial begin : stimulus
    bit held;
    held = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = id_t'($urandom_range(1, 65535));
    id_pool[0] = 16'hFFFF;
    id_pool[1] = 16'h0001;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.func           <= cst_pkg::FUNC_CONNECT;
    in_ch.session_id     <= '0;
    in_ch.requested_slot <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(cst_pkg::FUNC_CONNECT,    16'hFFFF, 8'hFF);
    issue(cst_pkg::FUNC_CONNECT,    16'h0001, 8'h00);
    issue(cst_pkg::FUNC_CONNECT,    16'hFFFF, 8'h00);
    issue(cst_pkg::FUNC_QUERY,      16'hFFFF, 8'h00);
    issue(cst_pkg::FUNC_QUERY,      16'h1234, 8'h00);
    issue(cst_pkg::FUNC_DISCONNECT, 16'hFFFF, 8'h00);
    issue(cst_pkg::FUNC_QUERY,      16'hFFFF, 8'h00);
    issue(cst_pkg::FUNC_CONNECT,    16'h5A5A, 8'h00);
    issue(cst_pkg::FUNC_ASSIGN,     16'h0001, 8'h07);
    issue(cst_pkg::FUNC_ASSIGN,     16'h0001, 8'h00);
    issue(cst_pkg::FUNC_ASSIGN_REQ, 16'hA5A5, 8'd15);
    issue(cst_pkg::FUNC_ASSIGN_REQ, 16'h0002, 8'd15);
    issue(cst_pkg::FUNC_ASSIGN_REQ, 16'h0003, 8'd255);
    issue(cst_pkg::FUNC_ASSIGN_REQ, 16'h0001, 8'd9);
    issue(cst_pkg::FUNC_ASSIGN_REQ, 16'h0004, 8'd16);
    issue(cst_pkg::FUNC_DISCONNECT, 16'h0001, 8'h00);
    issue(cst_pkg::FUNC_DISCONNECT, 16'h0002, 8'h00);
    issue(cst_pkg::FUNC_DISCONNECT, 16'h7777, 8'h00);
    issue(cst_pkg::FUNC_CONNECT,    16'h0000, 8'h00);
    issue(cst_pkg::FUNC_ASSIGN_REQ, 16'h0000, 8'd3);
    issue(cst_pkg::FUNC_QUERY,      16'h0000, 8'h00);
    for (int f = cst_pkg::FUNC_ASSIGN_REQ + 1; f < 8; f++)
      issue(func_t'(f), 16'hFFFF, 8'hFF);
    issue(cst_pkg::FUNC_ASSIGN_REQ, 16'h00FF, 8'd0);
    wait_drained();

    while (sent < NUM_COMMANDS) begin
      case ($urandom_range(0, 9))
        0, 1: repeat ($urandom_range(10, 20))
          issue(cst_pkg::FUNC_CONNECT, pick_id(), pick_req());
        2, 3: repeat ($urandom_range(10, 20))
          issue($urandom_range(0, 1) ? cst_pkg::FUNC_ASSIGN : cst_pkg::FUNC_ASSIGN_REQ,
                pick_id(), pick_req());
        4:    repeat ($urandom_range(10, 24))
          issue(cst_pkg::FUNC_DISCONNECT, pick_id(), pick_req());
        default: repeat (30) issue(pick_func(), pick_id(), pick_req());
      endcase
      if (!held && sent > 350) begin
        hold_requests <= hold_requests + 1;
        held = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("connection_and_slot_table_top regression: pass");
    end else begin
      $display("connection_and_slot_table_top regression: fail");
    end
    $finish;
  end

endmodule
